>>> hdl/tlss_pkg.sv
// Shared types and constants for the two-level sorted search unit.
package tlss_pkg;

  // Default number of segments (store holds SEGMENTS_DEF squared words)
  localparam int SEGMENTS_DEF = 64;

  // Fixed field widths
  localparam int VAL_W = 32;
  localparam int STS_W = 3;
  localparam int POS_W = 12;

  // Result status codes
  typedef enum logic [STS_W-1:0] {
    ST_FOUND        = 3'd0,
    ST_NOT_FOUND    = 3'd1,
    ST_LOADED       = 3'd2,
    ST_NOT_READY    = 3'd3,
    ST_FULL         = 3'd4,
    ST_OUT_OF_ORDER = 3'd5
  } status_t;

  // Input operation codes
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  // Source of the result position
  typedef enum logic [1:0] {
    POS_ZERO,
    POS_MIN,
    POS_PROBE
  } pos_sel_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_BS_ISSUE,
    S_BS_CMP,
    S_FLUSH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic     accept;
    logic     do_load;
    logic     scan_start;
    logic     scan_next;
    logic     seg_prev;
    logic     seg_cur;
    logic     bs_issue;
    logic     bs_update;
    logic     res_we;
    status_t  res_code;
    pos_sel_t pos_sel;
    logic     out_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_search;
    logic full;
    logic out_of_order;
    logic min_eq;
    logic min_gt;
    logic scan_first;
    logic scan_last;
    logic bs_empty;
    logic probe_eq;
  } sts_t;

endpackage

>>> hdl/tlss_ctrl.sv
// Controller state machine for the two-level sorted search unit.
module tlss_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  tlss_pkg::sts_t sts,
  output tlss_pkg::cmd_t cmd
);
  import tlss_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid flag: set when a result moves out, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.is_search && sts.full) state_next = S_SCAN;
        else                           state_next = S_FLUSH;
      end
      S_SCAN: begin
        priority if (sts.min_eq)                  state_next = S_FLUSH;
        else if (sts.min_gt && sts.scan_first)    state_next = S_FLUSH;
        else if (sts.min_gt || sts.scan_last)     state_next = S_BS_ISSUE;
        else                                      state_next = S_SCAN;
      end
      S_BS_ISSUE: begin
        if (sts.bs_empty) state_next = S_FLUSH;
        else              state_next = S_BS_CMP;
      end
      S_BS_CMP: begin
        if (sts.probe_eq) state_next = S_FLUSH;
        else              state_next = S_BS_ISSUE;
      end
      S_FLUSH: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd          = '0;
    cmd.res_code = ST_FOUND;
    cmd.pos_sel  = POS_ZERO;
    unique case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
      end
      S_EXEC: begin
        if (!sts.is_search) begin
          cmd.res_we = 1'b1;
          priority if (sts.full) begin
            cmd.res_code = ST_FULL;
          end else if (sts.out_of_order) begin
            cmd.res_code = ST_OUT_OF_ORDER;
          end else begin
            cmd.do_load  = 1'b1;
            cmd.res_code = ST_LOADED;
          end
        end else if (!sts.full) begin
          cmd.res_we   = 1'b1;
          cmd.res_code = ST_NOT_READY;
        end else begin
          cmd.scan_start = 1'b1;
        end
      end
      S_SCAN: begin
        priority if (sts.min_eq) begin
          cmd.res_we   = 1'b1;
          cmd.res_code = ST_FOUND;
          cmd.pos_sel  = POS_MIN;
        end else if (sts.min_gt && sts.scan_first) begin
          cmd.res_we   = 1'b1;
          cmd.res_code = ST_NOT_FOUND;
        end else if (sts.min_gt) begin
          cmd.seg_prev = 1'b1;
        end else if (sts.scan_last) begin
          cmd.seg_cur = 1'b1;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_BS_ISSUE: begin
        if (sts.bs_empty) begin
          cmd.res_we   = 1'b1;
          cmd.res_code = ST_NOT_FOUND;
        end else begin
          cmd.bs_issue = 1'b1;
        end
      end
      S_BS_CMP: begin
        if (sts.probe_eq) begin
          cmd.res_we   = 1'b1;
          cmd.res_code = ST_FOUND;
          cmd.pos_sel  = POS_PROBE;
        end else begin
          cmd.bs_update = 1'b1;
        end
      end
      S_FLUSH: begin
        cmd.out_load = !out_valid || out_ready;
      end
      default: begin
        cmd.accept = 1'b0;
      end
    endcase
  end

endmodule

>>> hdl/tlss_dp.sv
// Datapath: sorted store, segment minimums, scan and binary-search registers.
module tlss_dp #(
  parameter int SEGMENTS = tlss_pkg::SEGMENTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              operation,
  input  logic signed [tlss_pkg::VAL_W-1:0] value,
  input  tlss_pkg::cmd_t                    cmd,
  output tlss_pkg::sts_t                    sts,
  output logic [tlss_pkg::STS_W-1:0]        status,
  output logic [tlss_pkg::POS_W-1:0]        position
);
  import tlss_pkg::*;

  localparam int STORE_SIZE = SEGMENTS * SEGMENTS;
  localparam int SEG_W      = $clog2(SEGMENTS);
  localparam int IDX_W      = $clog2(STORE_SIZE);

  localparam logic [IDX_W:0]           STORE_FILL = (IDX_W+1)'(STORE_SIZE);
  localparam logic [IDX_W-1:0]         SEG_SIZE   = IDX_W'(SEGMENTS);
  localparam logic [SEG_W-1:0]         SEG_LAST   = SEG_W'(SEGMENTS - 1);
  localparam logic signed [SEG_W+1:0]  BS_HI_INIT = (SEG_W+2)'(SEGMENTS - 1);

  // Memories
  logic signed [VAL_W-1:0] store [STORE_SIZE];
  logic signed [VAL_W-1:0] mins  [SEGMENTS];
  logic signed [VAL_W-1:0] store_q;
  logic signed [VAL_W-1:0] min_q;

  // Item registers
  logic                    op_q;
  logic signed [VAL_W-1:0] key;

  // Fill state
  logic [IDX_W:0]          fill_count;
  logic [SEG_W-1:0]        off_cnt;
  logic [SEG_W-1:0]        seg_cnt;
  logic signed [VAL_W-1:0] last_loaded;

  // Search state
  logic [SEG_W-1:0]        scan_idx;
  logic [IDX_W-1:0]        base;
  logic signed [SEG_W+1:0] lo;
  logic signed [SEG_W+1:0] hi;
  logic [SEG_W-1:0]        mid;

  // Result holding and output registers
  status_t                 res_status;
  logic [IDX_W-1:0]        res_pos;
  logic [IDX_W+POS_W-1:0]  pos_ext;

  logic signed [SEG_W+1:0] bs_sum;
  logic [SEG_W-1:0]        mid_calc;
  logic [SEG_W-1:0]        min_raddr;
  logic [IDX_W-1:0]        store_raddr;
  logic [SEG_W-1:0]        seg_sel;
  logic [IDX_W-1:0]        min_pos;
  logic [IDX_W-1:0]        res_pos_next;

  // Address and position arithmetic
  assign bs_sum      = lo + hi;
  assign mid_calc    = bs_sum[SEG_W:1];
  assign store_raddr = base + IDX_W'(mid_calc);
  assign min_raddr   = cmd.scan_start ? '0 :
                       ((scan_idx == SEG_LAST) ? scan_idx : scan_idx + 1'b1);
  assign seg_sel     = cmd.seg_prev ? scan_idx - 1'b1 : scan_idx;
  assign min_pos     = IDX_W'(scan_idx) * SEG_SIZE;

  always_comb begin
    unique case (cmd.pos_sel)
      POS_MIN:   res_pos_next = min_pos;
      POS_PROBE: res_pos_next = base + IDX_W'(mid);
      default:   res_pos_next = '0;
    endcase
  end

  // Status to controller
  assign sts.is_search    = (op_q == OP_SEARCH);
  assign sts.full         = (fill_count == STORE_FILL);
  assign sts.out_of_order = (fill_count != '0) && (key < last_loaded);
  assign sts.min_eq       = (min_q == key);
  assign sts.min_gt       = (min_q > key);
  assign sts.scan_first   = (scan_idx == '0);
  assign sts.scan_last    = (scan_idx == SEG_LAST);
  assign sts.bs_empty     = (lo > hi);
  assign sts.probe_eq     = (store_q == key);

  // Sorted store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.do_load) begin
      store[fill_count[IDX_W-1:0]] <= key;
    end
    store_q <= store[store_raddr];
  end

  // Segment minimums: first word of each segment
  always_ff @(posedge clk) begin
    if (cmd.do_load && (off_cnt == '0)) begin
      mins[seg_cnt] <= key;
    end
    min_q <= mins[min_raddr];
  end

  // Fill counters
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      off_cnt     <= '0;
      seg_cnt     <= '0;
      last_loaded <= '0;
    end else if (cmd.do_load) begin
      fill_count  <= fill_count + 1'b1;
      last_loaded <= key;
      if (off_cnt == SEG_LAST) begin
        off_cnt <= '0;
        seg_cnt <= seg_cnt + 1'b1;
      end else begin
        off_cnt <= off_cnt + 1'b1;
      end
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q <= operation;
      key  <= value;
    end
  end

  // Linear scan and binary-search registers
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx <= '0;
    end else if (cmd.scan_next) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (cmd.seg_prev || cmd.seg_cur) begin
      base <= IDX_W'(seg_sel) * SEG_SIZE;
      lo   <= '0;
      hi   <= BS_HI_INIT;
    end else if (cmd.bs_update) begin
      if (store_q < key) lo <= $signed({2'b00, mid}) + 2'sd1;
      else               hi <= $signed({2'b00, mid}) - 2'sd1;
    end
    if (cmd.bs_issue) begin
      mid <= mid_calc;
    end
  end

  // Result holding register, then output register
  always_ff @(posedge clk) begin
    if (cmd.res_we) begin
      res_status <= cmd.res_code;
      res_pos    <= res_pos_next;
    end
  end

  assign pos_ext = {{POS_W{1'b0}}, res_pos};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status   <= res_status;
      position <= pos_ext[POS_W-1:0];
    end
  end

endmodule

>>> hdl/two_level_sorted_search_unit.sv
// Two-level sorted search unit: top level joining controller and datapath.
//
// Input channel (in_valid/in_ready) carries operation and value. A load
// (operation 0) appends value to a sorted store of SEGMENTS*SEGMENTS words;
// loads must arrive in ascending order. A search (operation 1) looks for
// value once the store is full. Every item yields one result item on the
// output channel (out_valid/out_ready): status and store position.
// Items are handled one at a time. A load or a rejected item has its result
// written to a holding register and then moved to the output register.
// A search scans the segment minimums (up to SEGMENTS, read from the
// minimums memory one a cycle), then makes binary-search probes into the
// store memory (up to log2(SEGMENTS)+1 probes) within the chosen segment.
// A finished result sits in an output register; the next item is accepted
// while it waits, and its own result then waits until the first is taken.
// Reset clears the fill count and last loaded word, so the store is empty;
// the memories themselves are not cleared and need no clearing pass.
module two_level_sorted_search_unit #(
  parameter int SEGMENTS = tlss_pkg::SEGMENTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              operation,
  input  logic signed [tlss_pkg::VAL_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tlss_pkg::STS_W-1:0]        status,
  output logic [tlss_pkg::POS_W-1:0]        position
);
  import tlss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tlss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tlss_dp #(
    .SEGMENTS (SEGMENTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .operation (operation),
    .value     (value),
    .cmd       (cmd),
    .sts       (sts),
    .status    (status),
    .position  (position)
  );

endmodule

>>> test/two_level_sorted_search_unit_test.sv
// Testbench for the two-level sorted search unit: load, search and refusal checks.
`timescale 1ns / 100ps

module two_level_sorted_search_unit_test;
  import tlss_pkg::*;

  localparam int SEGMENTS    = SEGMENTS_DEF;
  localparam int STORE_WORDS = SEGMENTS * SEGMENTS;
  localparam int HOLD_CYCLES = 400;

  typedef logic signed [VAL_W-1:0] word_t;

  localparam word_t WORD_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam word_t WORD_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  // One expected result, with the item that caused it for messages
  typedef struct {
    op_t              op;
    word_t            key;
    status_t          code;
    logic [POS_W-1:0] where;
  } outcome_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic             operation = 1'b0;
  word_t            value     = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [STS_W-1:0] status;
  logic [POS_W-1:0] position;

  // Idling control shared by both sides, and the long receiver hold-off
  logic steady      = 1'b0;
  logic hold_req    = 1'b0;
  logic hold_served = 1'b0;

  int error_count = 0;

  // Our own copy of the block's state
  word_t       stored_words  [STORE_WORDS];
  word_t       segment_floor [SEGMENTS];
  int unsigned words_held = 0;
  word_t       last_word  = '0;

  // Ascending contents planned for the store
  word_t planned_words [STORE_WORDS];

  outcome_t awaited_outcomes [$];

  always #2 clk = ~clk;

  two_level_sorted_search_unit #(
    .SEGMENTS (SEGMENTS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .position  (position)
  );

  task automatic report_mismatch(string what);
    if (error_count < 40) $display("%0t ns mismatch: %s", $time, what);
    error_count++;
  endtask

  // Apply one item to the local state and work out its result
  function automatic outcome_t predict_outcome(op_t op, word_t key);
    outcome_t res;
    int       seg;
    int       lo;
    int       hi;
    int       mid;
    int       i;
    int       idx;
    res.op    = op;
    res.key   = key;
    res.code  = ST_LOADED;
    res.where = '0;
    if (op == OP_LOAD) begin
      if (words_held >= STORE_WORDS) begin
        res.code = ST_FULL;
      end else if (words_held > 0 && key < last_word) begin
        res.code = ST_OUT_OF_ORDER;
      end else begin
        stored_words[words_held] = key;
        if (words_held % SEGMENTS == 0) segment_floor[words_held / SEGMENTS] = key;
        words_held++;
        last_word = key;
      end
      return res;
    end
    if (words_held < STORE_WORDS) begin
      res.code = ST_NOT_READY;
      return res;
    end
    // Linear scan of the segment minimums
    res.code = ST_NOT_FOUND;
    seg = SEGMENTS - 1;
    for (i = 0; i < SEGMENTS; i++) begin
      if (segment_floor[i] == key) begin
        idx       = i * SEGMENTS;
        res.code  = ST_FOUND;
        res.where = idx[POS_W-1:0];
        return res;
      end
      if (segment_floor[i] > key) begin
        if (i == 0) return res;
        seg = i - 1;
        break;
      end
    end
    // Binary search inside the chosen segment, first hit wins
    lo = 0;
    hi = SEGMENTS - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      idx = seg * SEGMENTS + mid;
      if (stored_words[idx] == key) begin
        res.code  = ST_FOUND;
        res.where = idx[POS_W-1:0];
        return res;
      end
      if (stored_words[idx] < key) lo = mid + 1;
      else hi = mid - 1;
    end
    return res;
  endfunction

  // Offer one item, hold it until taken, then record its expected result
  task automatic send_item(op_t op, word_t key);
    if (!steady && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(5, 90)) @(posedge clk);
      else repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    value     <= key;
    do @(posedge clk); while (!in_ready);
    awaited_outcomes.push_back(predict_outcome(op, key));
  endtask

  // Receiver: random back-pressure plus one long hold-off
  initial begin : result_taker
    int held;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        out_ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_served <= 1'b1;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 17);
      end
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin : result_checker
    outcome_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_outcomes.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d position %0d",
                                  status, position));
      end else begin
        want = awaited_outcomes.pop_front();
        if (status !== want.code)
          report_mismatch($sformatf("%s %0d: status %0d, wanted %s", want.op.name(),
                                    want.key, status, want.code.name()));
        if (position !== want.where)
          report_mismatch($sformatf("%s %0d: position %0d, wanted %0d", want.op.name(),
                                    want.key, position, want.where));
      end
    end
  end

  // Plan the store, then check refusals while it is still empty or partly loaded
  task automatic test_before_full();
    longint acc;
    int     k;
    int     run;
    int     pick;
    logic   keep;
    acc = longint'(WORD_MIN) + $urandom_range(1, 1 << 20);
    run = 0;
    for (k = 0; k < STORE_WORDS; k++) begin
      // duplicates across one boundary, and a run sharing three minimums
      keep = (k >= 5 * SEGMENTS - 2 && k <= 5 * SEGMENTS + 2) ||
             (k >= 31 * SEGMENTS - 4 && k <= 33 * SEGMENTS + 8);
      if (k > 0 && !keep) begin
        if (run > 0) begin
          run--;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 3) run = $urandom_range(8, 90);
          else if (pick < 30) acc = acc;
          else if (pick < 55) acc += $urandom_range(1, 3);
          else acc += $urandom_range(1, 1 << 22);
        end
      end
      if (acc > longint'(WORD_MAX) || k == STORE_WORDS - 1) acc = longint'(WORD_MAX);
      planned_words[k] = acc[VAL_W-1:0];
    end

    send_item(OP_SEARCH, '0);
    // first load goes in even though it is below the reset last word
    send_item(OP_LOAD, planned_words[0]);
    send_item(OP_LOAD, WORD_MIN);
    send_item(OP_LOAD, planned_words[1]);
    send_item(OP_SEARCH, WORD_MAX);
    send_item(OP_SEARCH, planned_words[0]);
  endtask

  // Fill the store, with refused loads and early searches mixed in
  task automatic test_fill();
    int    k;
    int    pick;
    word_t v;
    for (k = 2; k < STORE_WORDS; k++) begin
      if (k == 1000) steady <= 1'b1;
      if (k == 1600) steady <= 1'b0;
      if (k == 2500) hold_req <= 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        v = $urandom;
        if (v >= planned_words[k-1]) v = planned_words[k-1] - 1;
        send_item(OP_LOAD, v);
      end else if (pick < 13) begin
        send_item(OP_SEARCH, $urandom);
      end
      send_item(OP_LOAD, planned_words[k]);
    end
  endtask

  // Loads into a full store are refused whatever their value
  task automatic test_loads_when_full();
    send_item(OP_LOAD, WORD_MAX);
    send_item(OP_LOAD, WORD_MIN);
    send_item(OP_LOAD, planned_words[STORE_WORDS-1]);
  endtask

  task automatic test_directed_searches();
    send_item(OP_SEARCH, WORD_MIN);
    send_item(OP_SEARCH, planned_words[0] - 1);
    send_item(OP_SEARCH, planned_words[0]);
    send_item(OP_SEARCH, planned_words[SEGMENTS]);
    send_item(OP_SEARCH, planned_words[5 * SEGMENTS]);
    send_item(OP_SEARCH, planned_words[32 * SEGMENTS]);
    send_item(OP_SEARCH, planned_words[(SEGMENTS - 1) * SEGMENTS]);
    send_item(OP_SEARCH, WORD_MAX);
    send_item(OP_SEARCH, planned_words[1500]);
    send_item(OP_SEARCH, planned_words[1500] + 1);
    send_item(OP_SEARCH, planned_words[4000] - 1);
    send_item(OP_SEARCH, '0);
    send_item(OP_SEARCH, '1);
  endtask

  // Mostly keys from the store, with neighbours, minimums and noise
  task automatic test_random_searches();
    int    n;
    int    pick;
    word_t key;
    for (n = 0; n < 1300; n++) begin
      pick = $urandom_range(0, 99);
      key  = planned_words[$urandom_range(0, STORE_WORDS - 1)];
      if (pick < 55) begin
        send_item(OP_SEARCH, key);
      end else if (pick < 70) begin
        send_item(OP_SEARCH, $urandom_range(0, 1) ? key + 1 : key - 1);
      end else if (pick < 80) begin
        send_item(OP_SEARCH, planned_words[$urandom_range(0, SEGMENTS - 1) * SEGMENTS]);
      end else if (pick < 90) begin
        send_item(OP_SEARCH, $urandom);
      end else if (pick < 95) begin
        send_item(OP_SEARCH, $urandom_range(0, 1) ? WORD_MAX : WORD_MIN);
      end else begin
        send_item(OP_LOAD, $urandom);
      end
    end
  endtask

  initial begin : stimulus
    int guard;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_before_full();
    test_fill();
    test_loads_when_full();
    test_directed_searches();
    test_random_searches();
    in_valid <= 1'b0;

    for (guard = 0; guard < 100000 && awaited_outcomes.size() != 0; guard++)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (awaited_outcomes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_outcomes.size()));

    if (error_count == 0) begin
      $display("two_level_sorted_search_unit_test: done, clean");
    end else begin
      $display("two_level_sorted_search_unit_test: done, errors");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin : watchdog
    #20_000_000;
    $display("two_level_sorted_search_unit_test: done, errors");
    $finish;
  end

endmodule
